@@ sv/csv_record_field_splitter_defines.svh @@
// Assertion macros for the checker file of the CSV field splitter.
`ifndef CSV_RECORD_FIELD_SPLITTER_DEFINES_SVH
`define CSV_RECORD_FIELD_SPLITTER_DEFINES_SVH

// Same-cycle implication, sampled on the rising clock edge, off during reset.
`define CSVFS_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("csvfs assertion failed");

// Next-cycle implication, sampled on the rising clock edge, off during reset.
`define CSVFS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("csvfs assertion failed");

`endif

@@ sv/csvfs_pkg.sv @@
`default_nettype none

package csvfs_pkg;

  // Default size of the field buffer in bytes.
  localparam int unsigned FIELD_MAX_DEF = 32;

  // Configuration port.
  localparam int unsigned CFG_DATA_W = 8;
  localparam int unsigned CFG_IDX_W  = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_LIMIT_ENABLE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FIELD_LIMIT  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_JSON_MODE    = 2'd2;

  // Characters the splitter and the escape decoder look at.
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_NL     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_APOS   = 8'h27;
  localparam logic [7:0] CH_LC_B   = 8'h62;
  localparam logic [7:0] CH_LC_F   = 8'h66;
  localparam logic [7:0] CH_LC_N   = 8'h6E;
  localparam logic [7:0] CH_LC_R   = 8'h72;
  localparam logic [7:0] CH_LC_T   = 8'h74;
  localparam logic [7:0] CH_LC_U   = 8'h75;
  localparam logic [7:0] CH_BS_CTL = 8'h08;
  localparam logic [7:0] CH_FF_CTL = 8'h0C;
  localparam logic [7:0] CH_TAB    = 8'h09;

  typedef enum logic [1:0] {
    KIND_BYTE   = 2'd0,
    KIND_FIELD  = 2'd1,
    KIND_RECORD = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    ERR_NONE     = 2'd0,
    ERR_ESCAPE   = 2'd1,
    ERR_UNICODE  = 2'd2,
    ERR_OVERFLOW = 2'd3
  } err_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_RD,
    S_PROC,
    S_OUT,
    S_EOF,
    S_EOR
  } state_e;

  typedef enum logic [1:0] {
    DS_PLAIN,
    DS_ESC,
    DS_HEX
  } dec_st_e;

  typedef struct packed {
    logic       op;
    logic [7:0] char_byte;
  } in_item_t;

  typedef struct packed {
    kind_e      kind;
    logic [7:0] data_byte;
    logic       field_quoted;
    err_e       error_code;
    logic [7:0] field_count;
    logic       last_of_run;
  } out_item_t;

endpackage

`default_nettype wire

@@ sv/csvfs_ram.sv @@
`default_nettype none

module csvfs_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 32
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output      logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

@@ sv/csv_record_field_splitter.sv @@
// CSV record field splitter.
// Input channel: one item per character byte (op 0) or an end-of-stream mark
// (op 1), moved by in_valid_i / in_stall_o. Output channel: field bytes,
// end-of-field and end-of-record items on out_valid_o / out_stall_i; the
// last item caused by one input item carries last_of_run.
// A plain character is buffered as it is accepted, and the next item is
// taken in the following cycle. A comma, newline or end of stream that
// releases a field walks the buffer out through one shared decode unit:
// each stored byte goes through buffer read and decode, then an output load
// per byte it yields (none for an escape backslash, the unicode prefix or
// one of its first three digits). Then a buffer read finds the end of the
// buffer and the end of field is loaded, on a close followed by the end of
// record; a close with no field to emit loads only the end of record. The
// input is stalled for the whole walk. The user writes the configuration
// through cfg_we_i / cfg_index_i / cfg_wdata_i while the block is idle; the
// block itself does not enforce this. Reset clears the control state, the
// record state and the configuration registers; the buffer contents stay
// undefined. A result sits in the output register until taken; while the
// receiver stalls, the walk waits in place and nothing is lost.
`default_nettype none

module csv_record_field_splitter #(
  parameter int unsigned FIELD_MAX = csvfs_pkg::FIELD_MAX_DEF
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             cfg_we_i,
  input  wire logic [csvfs_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [csvfs_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  input  wire logic                             in_valid_i,
  output      logic                             in_stall_o,
  input  wire csvfs_pkg::in_item_t              in_item_i,
  output      logic                             out_valid_o,
  input  wire logic                             out_stall_i,
  output      csvfs_pkg::out_item_t             out_item_o
);

  // Length counter holds 0..FIELD_MAX; buffer address covers the entries.
  localparam int unsigned LW = $clog2(FIELD_MAX + 1);
  localparam int unsigned AW = $clog2(FIELD_MAX);

  // Hex digit decode: bit 4 is the valid flag, bits 3:0 the value.
  function automatic logic [4:0] hex_digit(input logic [7:0] c);
    logic [4:0] r;
    r = 5'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      r = {1'b1, 4'(c - 8'h30)};
    end else if (c >= 8'h61 && c <= 8'h66) begin
      r = {1'b1, 4'(c - 8'h57)};
    end else if (c >= 8'h41 && c <= 8'h46) begin
      r = {1'b1, 4'(c - 8'h37)};
    end
    return r;
  endfunction

  // Configuration registers.
  logic       limit_en_q;
  logic [7:0] field_limit_q;
  logic       json_mode_q;

  // Record state.
  csvfs_pkg::state_e state_q, state_d;
  logic [LW-1:0] field_len_q, field_len_d;
  logic          in_quotes_q, in_quotes_d;
  logic          quoted_seen_q, quoted_seen_d;
  logic          comma_seen_q, comma_seen_d;
  logic          prev_bs_q, prev_bs_d;
  logic [7:0]    value_count_q, value_count_d;
  logic          any_emitted_q, any_emitted_d;
  logic          overflowed_q, overflowed_d;

  // Walk state: read index, whether the walk closes the record, decoder state
  // and the bytes the decoder produced for the current buffer byte.
  logic [LW-1:0]          idx_q, idx_d;
  logic                   close_q, close_d;
  csvfs_pkg::dec_st_e     dst_q, dst_d;
  logic [15:0]            cp_q, cp_d;
  logic [1:0]             nd_q, nd_d;
  csvfs_pkg::err_e        derr_q, derr_d;
  logic [2:0][7:0]        pend_q, pend_d;
  logic [1:0]             pend_cnt_q, pend_cnt_d;

  // Output register.
  logic                 out_valid_q;
  csvfs_pkg::out_item_t out_q;
  logic                 load_en;
  csvfs_pkg::out_item_t load_item;
  logic                 slot_free;

  // Field buffer.
  logic          ram_we;
  logic [7:0]    ram_rdata;

  // Input item decode.
  logic       acc;
  logic [7:0] c_in;
  logic       ev_close, ev_comma, ev_quote, ev_append, prev_next;
  logic       count_needed, start_walk, cnt_ok;
  logic [8:0] cnt_next;
  logic [7:0] cnt_sat;

  // Shared decode unit outputs.
  logic                 json_dec;
  logic [1:0]           dec_cnt;
  logic [2:0][7:0]      dec_b;
  csvfs_pkg::dec_st_e   dec_dst;
  logic [15:0]          dec_cp;
  logic [1:0]           dec_nd;
  csvfs_pkg::err_e      dec_err;
  logic [4:0]           hex_r;

  assign in_stall_o  = (state_q != csvfs_pkg::S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;
  assign slot_free   = !out_valid_q || !out_stall_i;
  assign acc         = in_valid_i && (state_q == csvfs_pkg::S_IDLE);
  assign c_in        = in_item_i.char_byte;

  // Configuration writes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_en_q    <= 1'b0;
      field_limit_q <= 8'd0;
      json_mode_q   <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        csvfs_pkg::CFG_LIMIT_ENABLE: limit_en_q    <= cfg_wdata_i[0];
        csvfs_pkg::CFG_FIELD_LIMIT:  field_limit_q <= cfg_wdata_i[7:0];
        csvfs_pkg::CFG_JSON_MODE:    json_mode_q   <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  // Classify the incoming item. A byte after a backslash is always taken
  // literally, even a newline; a bare backslash is dropped.
  always_comb begin
    ev_close  = 1'b0;
    ev_comma  = 1'b0;
    ev_quote  = 1'b0;
    ev_append = 1'b0;
    prev_next = (c_in == csvfs_pkg::CH_BSLASH);
    if (in_item_i.op) begin
      ev_close = 1'b1;
    end else if (prev_bs_q) begin
      ev_append = 1'b1;
    end else if (c_in == csvfs_pkg::CH_NL) begin
      ev_close = 1'b1;
    end else if (c_in == csvfs_pkg::CH_QUOTE) begin
      ev_quote = 1'b1;
    end else if (c_in == csvfs_pkg::CH_COMMA) begin
      ev_comma  = !in_quotes_q;
      ev_append = in_quotes_q;
    end else if (c_in != csvfs_pkg::CH_BSLASH && c_in != csvfs_pkg::CH_CR) begin
      ev_append = 1'b1;
    end
  end

  // Field counting: the limit compares the unsaturated count, so once the
  // count has passed 255 no field gets through an enabled limit.
  assign cnt_next     = {1'b0, value_count_q} + 9'd1;
  assign cnt_ok       = !limit_en_q || (cnt_next <= {1'b0, field_limit_q});
  assign cnt_sat      = cnt_next[8] ? 8'hFF : cnt_next[7:0];
  assign count_needed = ev_comma || (ev_close && (comma_seen_q || !any_emitted_q));
  assign start_walk   = count_needed && cnt_ok;

  // Shared decode unit: one buffer byte per use.
  assign json_dec = quoted_seen_q && json_mode_q;
  assign hex_r    = hex_digit(ram_rdata);

  always_comb begin
    dec_cnt = 2'd0;
    dec_b   = '0;
    dec_dst = dst_q;
    dec_cp  = cp_q;
    dec_nd  = nd_q;
    dec_err = derr_q;
    if (!json_dec) begin
      dec_cnt    = 2'd1;
      dec_b[0]   = ram_rdata;
    end else begin
      unique case (dst_q)
        csvfs_pkg::DS_PLAIN: begin
          if (ram_rdata == csvfs_pkg::CH_BSLASH) begin
            dec_dst = csvfs_pkg::DS_ESC;
          end else begin
            dec_cnt  = 2'd1;
            dec_b[0] = ram_rdata;
          end
        end
        csvfs_pkg::DS_ESC: begin
          dec_dst = csvfs_pkg::DS_PLAIN;
          unique case (ram_rdata)
            csvfs_pkg::CH_QUOTE, csvfs_pkg::CH_BSLASH,
            csvfs_pkg::CH_SLASH, csvfs_pkg::CH_APOS: begin
              dec_cnt  = 2'd1;
              dec_b[0] = ram_rdata;
            end
            csvfs_pkg::CH_LC_B: begin
              dec_cnt  = 2'd1;
              dec_b[0] = csvfs_pkg::CH_BS_CTL;
            end
            csvfs_pkg::CH_LC_F: begin
              dec_cnt  = 2'd1;
              dec_b[0] = csvfs_pkg::CH_FF_CTL;
            end
            csvfs_pkg::CH_LC_N: begin
              dec_cnt  = 2'd1;
              dec_b[0] = csvfs_pkg::CH_NL;
            end
            csvfs_pkg::CH_LC_R: begin
              dec_cnt  = 2'd1;
              dec_b[0] = csvfs_pkg::CH_CR;
            end
            csvfs_pkg::CH_LC_T: begin
              dec_cnt  = 2'd1;
              dec_b[0] = csvfs_pkg::CH_TAB;
            end
            csvfs_pkg::CH_LC_U: begin
              dec_dst = csvfs_pkg::DS_HEX;
              dec_cp  = 16'd0;
              dec_nd  = 2'd0;
            end
            default: dec_err = csvfs_pkg::ERR_ESCAPE;
          endcase
        end
        csvfs_pkg::DS_HEX: begin
          if (!hex_r[4]) begin
            dec_err = csvfs_pkg::ERR_UNICODE;
          end else begin
            dec_cp = {cp_q[11:0], hex_r[3:0]};
            dec_nd = nd_q + 2'd1;
            if (nd_q == 2'd3) begin
              // Fourth digit: encode the code point as UTF-8.
              dec_dst = csvfs_pkg::DS_PLAIN;
              if (dec_cp < 16'h0080) begin
                dec_cnt  = 2'd1;
                dec_b[0] = dec_cp[7:0];
              end else if (dec_cp < 16'h0800) begin
                dec_cnt  = 2'd2;
                dec_b[0] = {3'b110, dec_cp[10:6]};
                dec_b[1] = {2'b10, dec_cp[5:0]};
              end else begin
                dec_cnt  = 2'd3;
                dec_b[0] = {4'b1110, dec_cp[15:12]};
                dec_b[1] = {2'b10, dec_cp[11:6]};
                dec_b[2] = {2'b10, dec_cp[5:0]};
              end
            end
          end
        end
        default: dec_dst = csvfs_pkg::DS_PLAIN;
      endcase
    end
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      csvfs_pkg::S_IDLE: begin
        if (acc) begin
          if (start_walk) begin
            state_d = csvfs_pkg::S_RD;
          end else if (ev_close) begin
            state_d = csvfs_pkg::S_EOR;
          end
        end
      end
      csvfs_pkg::S_RD: begin
        if (idx_q == field_len_q || derr_q != csvfs_pkg::ERR_NONE) begin
          state_d = csvfs_pkg::S_EOF;
        end else begin
          state_d = csvfs_pkg::S_PROC;
        end
      end
      csvfs_pkg::S_PROC: begin
        state_d = (dec_cnt == 2'd0) ? csvfs_pkg::S_RD : csvfs_pkg::S_OUT;
      end
      csvfs_pkg::S_OUT: begin
        if (slot_free && pend_cnt_q == 2'd1) begin
          state_d = csvfs_pkg::S_RD;
        end
      end
      csvfs_pkg::S_EOF: begin
        if (slot_free) begin
          state_d = close_q ? csvfs_pkg::S_EOR : csvfs_pkg::S_IDLE;
        end
      end
      csvfs_pkg::S_EOR: begin
        if (slot_free) begin
          state_d = csvfs_pkg::S_IDLE;
        end
      end
      default: state_d = csvfs_pkg::S_IDLE;
    endcase
  end

  // Datapath and result generation.
  always_comb begin
    field_len_d   = field_len_q;
    in_quotes_d   = in_quotes_q;
    quoted_seen_d = quoted_seen_q;
    comma_seen_d  = comma_seen_q;
    prev_bs_d     = prev_bs_q;
    value_count_d = value_count_q;
    any_emitted_d = any_emitted_q;
    overflowed_d  = overflowed_q;
    idx_d         = idx_q;
    close_d       = close_q;
    dst_d         = dst_q;
    cp_d          = cp_q;
    nd_d          = nd_q;
    derr_d        = derr_q;
    pend_d        = pend_q;
    pend_cnt_d    = pend_cnt_q;
    ram_we        = 1'b0;
    load_en       = 1'b0;
    load_item     = '0;
    unique case (state_q)
      csvfs_pkg::S_IDLE: begin
        if (acc) begin
          if (!ev_close) begin
            prev_bs_d = prev_next;
          end
          if (ev_append) begin
            if (field_len_q < LW'(FIELD_MAX)) begin
              ram_we      = 1'b1;
              field_len_d = field_len_q + LW'(1);
            end else begin
              overflowed_d = 1'b1;
            end
          end
          if (ev_quote) begin
            in_quotes_d = !in_quotes_q;
            if (!in_quotes_q) begin
              quoted_seen_d = 1'b1;
            end
          end
          if (count_needed) begin
            value_count_d = cnt_sat;
          end
          if (ev_comma) begin
            comma_seen_d = 1'b1;
            // A field beyond the limit is dropped at once; quoted_seen stays.
            if (!cnt_ok) begin
              field_len_d  = '0;
              overflowed_d = 1'b0;
            end
          end
          if (start_walk) begin
            idx_d      = '0;
            close_d    = ev_close;
            dst_d      = csvfs_pkg::DS_PLAIN;
            cp_d       = 16'd0;
            nd_d       = 2'd0;
            derr_d     = csvfs_pkg::ERR_NONE;
            pend_cnt_d = 2'd0;
          end
        end
      end
      csvfs_pkg::S_RD: begin
        if (idx_q != field_len_q && derr_q == csvfs_pkg::ERR_NONE) begin
          idx_d = idx_q + LW'(1);
        end
      end
      csvfs_pkg::S_PROC: begin
        pend_d     = dec_b;
        pend_cnt_d = dec_cnt;
        dst_d      = dec_dst;
        cp_d       = dec_cp;
        nd_d       = dec_nd;
        derr_d     = dec_err;
      end
      csvfs_pkg::S_OUT: begin
        if (slot_free) begin
          load_en             = 1'b1;
          load_item.kind      = csvfs_pkg::KIND_BYTE;
          load_item.data_byte = pend_q[0];
          pend_d              = {8'h00, pend_q[2], pend_q[1]};
          pend_cnt_d          = pend_cnt_q - 2'd1;
        end
      end
      csvfs_pkg::S_EOF: begin
        if (slot_free) begin
          load_en                = 1'b1;
          load_item.kind         = csvfs_pkg::KIND_FIELD;
          load_item.field_quoted = quoted_seen_q;
          // A decode error takes precedence over the overflow flag.
          if (derr_q != csvfs_pkg::ERR_NONE) begin
            load_item.error_code = derr_q;
          end else if (overflowed_q) begin
            load_item.error_code = csvfs_pkg::ERR_OVERFLOW;
          end else begin
            load_item.error_code = csvfs_pkg::ERR_NONE;
          end
          load_item.last_of_run = !close_q;
          any_emitted_d         = 1'b1;
          if (!close_q) begin
            quoted_seen_d = 1'b0;
            field_len_d   = '0;
            overflowed_d  = 1'b0;
          end
        end
      end
      csvfs_pkg::S_EOR: begin
        if (slot_free) begin
          load_en               = 1'b1;
          load_item.kind        = csvfs_pkg::KIND_RECORD;
          load_item.field_count = value_count_q;
          load_item.last_of_run = 1'b1;
          field_len_d   = '0;
          in_quotes_d   = 1'b0;
          quoted_seen_d = 1'b0;
          comma_seen_d  = 1'b0;
          prev_bs_d     = 1'b0;
          value_count_d = 8'd0;
          any_emitted_d = 1'b0;
          overflowed_d  = 1'b0;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= csvfs_pkg::S_IDLE;
      field_len_q   <= '0;
      in_quotes_q   <= 1'b0;
      quoted_seen_q <= 1'b0;
      comma_seen_q  <= 1'b0;
      prev_bs_q     <= 1'b0;
      value_count_q <= 8'd0;
      any_emitted_q <= 1'b0;
      overflowed_q  <= 1'b0;
      idx_q         <= '0;
      close_q       <= 1'b0;
      dst_q         <= csvfs_pkg::DS_PLAIN;
      nd_q          <= 2'd0;
      derr_q        <= csvfs_pkg::ERR_NONE;
      pend_cnt_q    <= 2'd0;
      out_valid_q   <= 1'b0;
    end else begin
      state_q       <= state_d;
      field_len_q   <= field_len_d;
      in_quotes_q   <= in_quotes_d;
      quoted_seen_q <= quoted_seen_d;
      comma_seen_q  <= comma_seen_d;
      prev_bs_q     <= prev_bs_d;
      value_count_q <= value_count_d;
      any_emitted_q <= any_emitted_d;
      overflowed_q  <= overflowed_d;
      idx_q         <= idx_d;
      close_q       <= close_d;
      dst_q         <= dst_d;
      nd_q          <= nd_d;
      derr_q        <= derr_d;
      pend_cnt_q    <= pend_cnt_d;
      if (load_en) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    cp_q   <= cp_d;
    pend_q <= pend_d;
    if (load_en) begin
      out_q <= load_item;
    end
  end

  csvfs_ram #(
    .WIDTH (8),
    .DEPTH (FIELD_MAX)
  ) u_buf (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (field_len_q[AW-1:0]),
    .wdata_i (c_in),
    .raddr_i (idx_q[AW-1:0]),
    .rdata_o (ram_rdata)
  );

endmodule

`default_nettype wire

@@ sv/csvfs_checker.sv @@
`default_nettype none
`include "csv_record_field_splitter_defines.svh"

module csvfs_checker (
  input wire logic                 clk_i,
  input wire logic                 rst_ni,
  input wire logic                 in_valid_i,
  input wire logic                 in_stall_o,
  input wire csvfs_pkg::in_item_t  in_item_i,
  input wire logic                 out_valid_o,
  input wire logic                 out_stall_i,
  input wire csvfs_pkg::out_item_t out_item_o
);

  // A result held by the receiver stays offered.
  `CSVFS_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i, out_valid_o)

  // Only field bytes carry data.
  `CSVFS_ASSERT_NOW(a_data_zero, clk_i, rst_ni,
    out_valid_o && out_item_o.kind != csvfs_pkg::KIND_BYTE, out_item_o.data_byte == 8'd0)

  // A field byte is never the final result of an item; an end of record always is.
  `CSVFS_ASSERT_NOW(a_byte_not_last, clk_i, rst_ni,
    out_valid_o && out_item_o.kind == csvfs_pkg::KIND_BYTE, !out_item_o.last_of_run)
  `CSVFS_ASSERT_NOW(a_eor_last, clk_i, rst_ni,
    out_valid_o && out_item_o.kind == csvfs_pkg::KIND_RECORD, out_item_o.last_of_run)

  // End of stream always produces a record close, so the input stalls next.
  `CSVFS_ASSERT_NEXT(a_eos_busy, clk_i, rst_ni,
    in_valid_i && !in_stall_o && in_item_i.op, in_stall_o)

endmodule

bind csv_record_field_splitter csvfs_checker u_csvfs_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .in_item_i   (in_item_i),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_item_o  (out_item_o)
);

`default_nettype wire

@@ test/csv_record_field_splitter_checker.sv @@
module csv_record_field_splitter_checker
  import csvfs_pkg::*;
#(
  parameter int unsigned FIELD_MAX = FIELD_MAX_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  input  logic                  in_valid_i,
  input  logic                  in_stall_i,
  input  in_item_t              in_item_i,
  input  logic                  out_valid_i,
  input  logic                  out_stall_i,
  input  out_item_t             out_item_i,
  output int unsigned           fail_count_o,
  output int unsigned           pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  // Shadow of the configuration registers.
  logic       limit_on;
  logic [7:0] limit_max;
  logic       json_on;

  // Shadow of the record state.
  logic [7:0]  field_bytes [FIELD_MAX];
  int unsigned field_len;
  logic        quoting;
  logic        saw_quote;
  logic        saw_comma;
  logic        literal_next;
  logic [7:0]  fields_in_rec;
  logic        field_sent;
  logic        too_long;

  // Results owed by the block, oldest first.
  out_item_t   tokens_due[$];
  int unsigned fails;

  function automatic void add_token(input kind_e k, input logic [7:0] d, input logic q,
                                    input err_e e, input logic [7:0] cnt);
    out_item_t t;
    t.kind         = k;
    t.data_byte    = d;
    t.field_quoted = q;
    t.error_code   = e;
    t.field_count  = cnt;
    t.last_of_run  = 1'b0;
    tokens_due.insert(tokens_due.size(), t);
  endfunction

  function automatic void add_byte(input logic [7:0] d);
    add_token(KIND_BYTE, d, 1'b0, ERR_NONE, 8'd0);
  endfunction

  function automatic void add_utf8(input logic [15:0] cp);
    if (cp < 16'h0080) begin
      add_byte(cp[7:0]);
    end else if (cp < 16'h0800) begin
      add_byte({3'b110, cp[10:6]});
      add_byte({2'b10, cp[5:0]});
    end else begin
      add_byte({4'b1110, cp[15:12]});
      add_byte({2'b10, cp[11:6]});
      add_byte({2'b10, cp[5:0]});
    end
  endfunction

  function automatic int hex_nibble(input logic [7:0] c);
    if (c >= "0" && c <= "9") return c - "0";
    if (c >= "a" && c <= "f") return c - "a" + 10;
    if (c >= "A" && c <= "F") return c - "A" + 10;
    return -1;
  endfunction

  // Walks the buffered field out, decoding JSON escapes when the field was
  // quoted and JSON mode is on; a decode error stops the walk.
  function automatic void release_field();
    int unsigned n;
    int unsigned i;
    int unsigned digits;
    int          h;
    err_e        err;
    dec_st_e     st;
    logic [15:0] cp;
    logic [7:0]  c;
    n      = (field_len < FIELD_MAX) ? field_len : FIELD_MAX;
    err    = ERR_NONE;
    st     = DS_PLAIN;
    cp     = '0;
    digits = 0;
    if (saw_quote && json_on) begin
      for (i = 0; i < n && err == ERR_NONE; i++) begin
        c = field_bytes[i];
        case (st)
          DS_PLAIN: begin
            if (c == CH_BSLASH) st = DS_ESC;
            else add_byte(c);
          end
          DS_ESC: begin
            st = DS_PLAIN;
            case (c)
              CH_QUOTE, CH_BSLASH, CH_SLASH, CH_APOS: add_byte(c);
              CH_LC_B: add_byte(CH_BS_CTL);
              CH_LC_F: add_byte(CH_FF_CTL);
              CH_LC_N: add_byte(CH_NL);
              CH_LC_R: add_byte(CH_CR);
              CH_LC_T: add_byte(CH_TAB);
              CH_LC_U: begin
                st     = DS_HEX;
                cp     = '0;
                digits = 0;
              end
              default: err = ERR_ESCAPE;
            endcase
          end
          default: begin
            h = hex_nibble(c);
            if (h < 0) begin
              err = ERR_UNICODE;
            end else begin
              cp = {cp[11:0], h[3:0]};
              digits++;
              if (digits == 4) begin
                add_utf8(cp);
                st = DS_PLAIN;
              end
            end
          end
        endcase
      end
    end else begin
      for (i = 0; i < n; i++) add_byte(field_bytes[i]);
    end
    // A decode error hides the overflow flag.
    if (err == ERR_NONE && too_long) err = ERR_OVERFLOW;
    add_token(KIND_FIELD, 8'd0, saw_quote, err, 8'd0);
  endfunction

  // Counts a field and tells whether it is within the limit. The compare is
  // made on the unsaturated count.
  function automatic logic tally_field();
    int unsigned nxt;
    logic        ok;
    nxt = fields_in_rec + 1;
    ok  = !limit_on || nxt <= limit_max;
    fields_in_rec = (nxt > 255) ? 8'd255 : nxt[7:0];
    return ok;
  endfunction

  function automatic void store_byte(input logic [7:0] c);
    if (field_len < FIELD_MAX) begin
      field_bytes[field_len] = c;
      field_len++;
    end else begin
      too_long = 1'b1;
    end
  endfunction

  function automatic void reset_record();
    field_len     = 0;
    quoting       = 1'b0;
    saw_quote     = 1'b0;
    saw_comma     = 1'b0;
    literal_next  = 1'b0;
    fields_in_rec = 8'd0;
    field_sent    = 1'b0;
    too_long      = 1'b0;
  endfunction

  function automatic void end_record();
    if (saw_comma || !field_sent) begin
      if (tally_field()) begin
        release_field();
        field_sent = 1'b1;
      end
    end
    add_token(KIND_RECORD, 8'd0, 1'b0, ERR_NONE, fields_in_rec);
    reset_record();
  endfunction

  // Predicts the results of one accepted input item.
  function automatic void split_item(input in_item_t it);
    int unsigned before_n;
    out_item_t   tail;
    logic [7:0]  c;
    before_n = tokens_due.size();
    c        = it.char_byte;
    if (it.op) begin
      // End of stream closes the record just like a newline.
      end_record();
    end else if (literal_next) begin
      store_byte(c);
      literal_next = (c == CH_BSLASH);
    end else if (c == CH_NL) begin
      end_record();
    end else begin
      if (c == CH_QUOTE) begin
        quoting = !quoting;
        if (quoting) saw_quote = 1'b1;
      end else if (c == CH_COMMA && !quoting) begin
        if (tally_field()) begin
          release_field();
          field_sent = 1'b1;
          saw_quote  = 1'b0;
        end
        field_len = 0;
        too_long  = 1'b0;
        saw_comma = 1'b1;
      end else if (c != CH_BSLASH && c != CH_CR) begin
        store_byte(c);
      end
      literal_next = (c == CH_BSLASH);
    end
    if (tokens_due.size() > before_n) begin
      tail = tokens_due[tokens_due.size() - 1];
      tail.last_of_run = 1'b1;
      tokens_due[tokens_due.size() - 1] = tail;
    end
  endfunction

  task automatic check_field(input string name, input logic [7:0] want,
                             input logic [7:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      fails++;
    end
  endtask

  task automatic check_token(input out_item_t got);
    out_item_t want;
    if (tokens_due.size() == 0) begin
      $error("result with nothing expected: kind %0d, data_byte %0h",
             got.kind, got.data_byte);
      fails++;
    end else begin
      want = tokens_due.pop_front();
      check_field("kind", want.kind, got.kind);
      check_field("data_byte", want.data_byte, got.data_byte);
      check_field("field_quoted", want.field_quoted, got.field_quoted);
      check_field("error_code", want.error_code, got.error_code);
      check_field("field_count", want.field_count, got.field_count);
      check_field("last_of_run", want.last_of_run, got.last_of_run);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_on  = 1'b0;
      limit_max = 8'd0;
      json_on   = 1'b0;
      reset_record();
      tokens_due.delete();
      fails = 0;
      fail_count_o <= 0;
      pending_o    <= 0;
    end else begin
      // Results first, so that a result can never be matched against an
      // expectation raised at the same edge.
      if (out_valid_i && !out_stall_i) check_token(out_item_i);
      if (in_valid_i && !in_stall_i) split_item(in_item_i);
      if (cfg_we_i) begin
        case (cfg_index_i)
          CFG_LIMIT_ENABLE: limit_on  = cfg_wdata_i[0];
          CFG_FIELD_LIMIT:  limit_max = cfg_wdata_i[7:0];
          CFG_JSON_MODE:    json_on   = cfg_wdata_i[0];
          default: ;
        endcase
      end
      fail_count_o <= fails;
      pending_o    <= tokens_due.size();
    end
  end

endmodule

@@ test/csv_record_field_splitter_tb.sv @@
module csv_record_field_splitter_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import csvfs_pkg::*;

  localparam int unsigned FIELD_MAX    = 32;
  localparam int          CLK_HALF     = 10;
  localparam int          RESET_CYCLES = 8;
  // Cycles allowed for a plain character that causes no result to finish
  // inside the block before its configuration is touched.
  localparam int          SETTLE_CYCLES = 16;
  // No correct run goes this long without moving an item on some channel.
  localparam int          IDLE_LIMIT   = 2000;
  localparam int          PHASE_ITEMS  = 25;
  localparam int          NUM_PHASES   = 6;

  // Input item opcodes.
  localparam logic OP_CHAR = 1'b0;
  localparam logic OP_EOS  = 1'b1;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = CFG_LIMIT_ENABLE;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  in_item_t              in_item = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  out_item_t             out_item;
  int unsigned           fail_count;
  int unsigned           pending;

  // Pace of each side: 0 never idles, 1 idles for a drawn gap on every item,
  // 2 idles only now and then. Both change as the run goes on, so there are
  // long stretches with no idling between stretches full of gaps.
  int tx_pace = 0;
  int rx_pace = 0;
  int items_sent = 0;

  always #CLK_HALF clk = ~clk;

  csv_record_field_splitter #(
    .FIELD_MAX(FIELD_MAX)
  ) dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .cfg_we_i   (cfg_we),
    .cfg_index_i(cfg_index),
    .cfg_wdata_i(cfg_wdata),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_item_i  (in_item),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_item_o (out_item)
  );

  csv_record_field_splitter_checker #(
    .FIELD_MAX(FIELD_MAX)
  ) checker_i (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_index_i (cfg_index),
    .cfg_wdata_i (cfg_wdata),
    .in_valid_i  (in_valid),
    .in_stall_i  (in_stall),
    .in_item_i   (in_item),
    .out_valid_i (out_valid),
    .out_stall_i (out_stall),
    .out_item_i  (out_item),
    .fail_count_o(fail_count),
    .pending_o   (pending)
  );

  function automatic int pick_gap(input int pace);
    case (pace)
      0: return 0;
      1: return $urandom_range(0, 17);
      default: return ($urandom_range(0, 3) == 0) ? $urandom_range(0, 17) : 0;
    endcase
  endfunction

  // The receiver. After every result it takes, it draws how many cycles of
  // valid it lets pass with stall high before it takes the next one. The
  // count only runs down while a result is offered, so stall is often
  // already high when the next result shows up.
  int stall_left = 0;
  always @(posedge clk) begin
    if (out_valid && !out_stall) begin
      if ($urandom_range(0, 19) == 0) rx_pace = $urandom_range(0, 2);
      stall_left = pick_gap(rx_pace);
      out_stall <= (stall_left != 0);
    end else if (out_valid && stall_left != 0) begin
      stall_left--;
      out_stall <= (stall_left != 0);
    end
  end

  // Watchdog: any accepted item or register write restarts the count.
  int quiet_cycles = 0;
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= IDLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // Offers one item after a drawn gap and returns at the edge that takes it.
  // When the gap is zero, valid simply stays high into the next item.
  task automatic send_item(input logic op, input logic [7:0] b);
    int       gap;
    in_item_t it;
    gap          = pick_gap(tx_pace);
    it.op        = op;
    it.char_byte = b;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_item  <= it;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    items_sent++;
  endtask

  task automatic send_char(input logic [7:0] b);
    send_item(OP_CHAR, b);
  endtask

  // Writes all three registers on consecutive edges; the block must be idle.
  task automatic set_config(input logic le, input logic [7:0] lim, input logic jm);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_LIMIT_ENABLE;
    cfg_wdata <= {7'd0, le};
    @(posedge clk);
    cfg_index <= CFG_FIELD_LIMIT;
    cfg_wdata <= lim;
    @(posedge clk);
    cfg_index <= CFG_JSON_MODE;
    cfg_wdata <= {7'd0, jm};
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Waits until every predicted result has been taken, then lets a trailing
  // character that causes no result drain out of the block.
  task automatic wait_idle();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Any byte that is not a separator, quote, backslash or line end.
  function automatic logic [7:0] plain_char();
    logic [7:0] b;
    do begin
      b = 8'($urandom_range(0, 255));
    end while (b == CH_COMMA || b == CH_QUOTE || b == CH_BSLASH ||
               b == CH_NL || b == CH_CR);
    return b;
  endfunction

  // Mostly hex digits of both cases, now and then a character that is not.
  function automatic logic [7:0] hex_char();
    int v;
    v = $urandom_range(0, 22);
    if (v < 10) return 8'(v) + "0";
    if (v < 16) return 8'(v - 10) + "a";
    if (v < 22) return 8'(v - 16) + "A";
    return "g";
  endfunction

  // A backslash escape as JSON knows it, an unknown one, or a unicode
  // escape that may be cut short.
  task automatic send_json_escape();
    int pick;
    int digits;
    int k;
    pick = $urandom_range(0, 11);
    send_char(CH_BSLASH);
    case (pick)
      0: send_char(CH_QUOTE);
      1: send_char(CH_BSLASH);
      2: send_char(CH_SLASH);
      3: send_char(CH_APOS);
      4: send_char(CH_LC_B);
      5: send_char(CH_LC_F);
      6: send_char(CH_LC_N);
      7: send_char(CH_LC_R);
      8: send_char(CH_LC_T);
      9: send_char("q");
      default: begin
        send_char(CH_LC_U);
        digits = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 3) : 4;
        for (k = 0; k < digits; k++) send_char(hex_char());
      end
    endcase
  endtask

  // One field: now and then a long plain one that may run past the buffer,
  // otherwise a short mix of plain bytes, escapes, quotes and stray CRs.
  task automatic send_field();
    int   units;
    int   k;
    int   pick;
    logic open_q;
    if ($urandom_range(0, 11) == 0) begin
      units = $urandom_range(FIELD_MAX - 2, FIELD_MAX + 8);
      for (k = 0; k < units; k++) send_char(plain_char());
    end else begin
      units  = $urandom_range(0, 6);
      open_q = 1'b0;
      if ($urandom_range(0, 1) == 1) begin
        send_char(CH_QUOTE);
        open_q = 1'b1;
      end
      for (k = 0; k < units; k++) begin
        pick = $urandom_range(0, 9);
        if (pick < 5) begin
          send_char(plain_char());
        end else if (pick < 7) begin
          send_json_escape();
        end else if (pick == 7) begin
          // Inside quotes a comma is just data.
          send_char(open_q ? CH_COMMA : CH_CR);
        end else if (pick == 8) begin
          send_char(CH_QUOTE);
          open_q = !open_q;
        end else begin
          send_char(CH_CR);
        end
      end
      if (open_q) send_char(CH_QUOTE);
    end
  endtask

  // A well-formed record with random content, closed by LF, CR LF or the
  // end-of-stream mark (whose byte is don't-care and so drawn at random).
  task automatic send_record();
    int nf;
    int k;
    tx_pace = $urandom_range(0, 2);
    nf = ($urandom_range(0, 15) == 0) ? $urandom_range(6, 12) : $urandom_range(1, 4);
    for (k = 0; k < nf; k++) begin
      if (k != 0) send_char(CH_COMMA);
      send_field();
    end
    if ($urandom_range(0, 7) == 0) send_char(CH_COMMA);
    case ($urandom_range(0, 3))
      0: begin
        send_char(CH_CR);
        send_char(CH_NL);
      end
      1: send_item(OP_EOS, 8'($urandom_range(0, 255)));
      default: send_char(CH_NL);
    endcase
  endtask

  // A short burst of arbitrary bytes and stream ends.
  task automatic send_noise();
    int n;
    int k;
    n = $urandom_range(1, 6);
    for (k = 0; k < n; k++) begin
      send_item(($urandom_range(0, 7) == 0) ? OP_EOS : OP_CHAR,
                8'($urandom_range(0, 255)));
    end
  endtask

  // 257 empty fields in one record: the count goes past 255 and saturates,
  // and from the 256th field on nothing passes even the widest limit.
  task automatic send_crowded_record();
    int k;
    tx_pace = 2;
    for (k = 0; k < 256; k++) send_char(CH_COMMA);
    send_char(CH_NL);
  endtask

  initial begin
    int phase;
    int target;

    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part, limit off and JSON decoding on.
    set_config(1'b0, 8'd0, 1'b1);
    tx_pace = 0;
    // Unquoted field holding the lowest and highest byte values.
    send_char(8'h00);
    send_char(8'hFF);
    send_char(CH_COMMA);
    // Quoted part with a comma inside, then an escaped backslash that in turn
    // makes the following comma literal, a dropped CR, and a newline. The
    // stored backslash-comma pair is an unknown JSON escape.
    send_char(CH_QUOTE);
    send_char("a");
    send_char(CH_COMMA);
    send_char("b");
    send_char(CH_QUOTE);
    send_char(CH_BSLASH);
    send_char(CH_BSLASH);
    send_char(CH_COMMA);
    send_char(CH_CR);
    send_char("x");
    send_char(CH_NL);
    // A record with nothing in it still yields one empty field.
    send_item(OP_EOS, 8'hFF);
    // A unicode escape that becomes a two-byte UTF-8 sequence.
    send_char(CH_QUOTE);
    send_char(CH_BSLASH);
    send_char(CH_LC_U);
    send_char("0");
    send_char("0");
    send_char("e");
    send_char("9");
    send_char(CH_QUOTE);
    send_item(OP_EOS, 8'h00);

    // Random part: one register setting per phase, the extremes among them.
    for (phase = 0; phase < NUM_PHASES; phase++) begin
      wait_idle();
      case (phase)
        0: set_config(1'b0, 8'($urandom_range(0, 255)), 1'b1);
        1: set_config(1'b1, 8'd0, 1'b0);
        2: set_config(1'b1, 8'd255, 1'b1);
        3: set_config(1'b1, 8'($urandom_range(1, 4)), 1'b1);
        4: set_config(1'b0, 8'd255, 1'b0);
        default: set_config(1'($urandom_range(0, 1)), 8'($urandom_range(0, 6)),
                            1'($urandom_range(0, 1)));
      endcase
      target = items_sent + PHASE_ITEMS;
      if (phase == 2) send_crowded_record();
      while (items_sent < target) begin
        if ($urandom_range(0, 6) == 0) send_noise();
        else send_record();
      end
    end

    wait_idle();
    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
